// ===== sv/atl_pkg.sv =====
// ----------------------------------------------------------------------------
// atl_pkg: shared types and constants of the token lexer
// Result kinds, error codes, the result record and the queue entry that
// carries up to two results of one input beat.
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        K_TEXT  = 3'd0,
        K_SEND  = 3'd1,
        K_OPEN  = 3'd2,
        K_CLOSE = 3'd3,
        K_EQ    = 3'd4,
        K_END   = 3'd5,
        K_ERR   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        E_UNTERM  = 2'd0,
        E_SLASH   = 2'd1,
        E_COMMENT = 2'd2,
        E_HEX     = 2'd3
    } err_t;

    // Packed so that kind sits in the lowest bits.
    typedef struct packed {
        err_t       err;
        logic [7:0] ch;
        kind_t      kind;
    } res_t;

    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } qent_t;

endpackage

// ===== sv/atl_front.sv =====
// ----------------------------------------------------------------------------
// atl_front: lexer state machine
// Classifies each accepted input beat and forms the zero, one or two results
// it causes as one queue entry.
// ----------------------------------------------------------------------------
module atl_front import atl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       push,
    output qent_t      ent
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_WORD  = 10'b0000000010,
        ST_STR   = 10'b0000000100,
        ST_ESC   = 10'b0000001000,
        ST_SLASH = 10'b0000010000,
        ST_LINE  = 10'b0000100000,
        ST_BLOCK = 10'b0001000000,
        ST_STAR  = 10'b0010000000,
        ST_HEX1  = 10'b0100000000,
        ST_HEX2  = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] hex_reg, hex_next;

    logic       is_ws, is_delim;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       idle_has;
    res_t       idle_res;
    state_t     idle_state;
    logic       has0;

    always_comb begin
        is_ws    = in_byte inside {8'h20, 8'h09, 8'h0d, 8'h0a};
        is_delim = end_of_input || is_ws || (in_byte inside {"{", "}", "=", "/"});
    end

    // Hex digit decode; end of input never counts as a digit.
    always_comb begin
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (!end_of_input) begin
            if (in_byte inside {["0":"9"]}) begin
                hex_ok  = 1'b1;
                hex_val = in_byte[3:0];
            end else if (in_byte inside {["a":"f"]}) begin
                hex_ok  = 1'b1;
                hex_val = 4'(in_byte - 8'h57);
            end else if (in_byte inside {["A":"F"]}) begin
                hex_ok  = 1'b1;
                hex_val = 4'(in_byte - 8'h37);
            end
        end
    end

    // What the idle state does with this beat; a word delimiter reuses it.
    always_comb begin
        idle_has   = 1'b0;
        idle_res   = '0;
        idle_state = ST_IDLE;
        if (end_of_input) begin
            idle_has      = 1'b1;
            idle_res.kind = K_END;
        end else if (!is_ws) begin
            case (in_byte)
                "\"": idle_state = ST_STR;
                "/":  idle_state = ST_SLASH;
                "{": begin
                    idle_has      = 1'b1;
                    idle_res.kind = K_OPEN;
                end
                "}": begin
                    idle_has      = 1'b1;
                    idle_res.kind = K_CLOSE;
                end
                "=": begin
                    idle_has      = 1'b1;
                    idle_res.kind = K_EQ;
                end
                default: begin
                    idle_has      = 1'b1;
                    idle_res.kind = K_TEXT;
                    idle_res.ch   = in_byte;
                    idle_state    = ST_WORD;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        hex_next   = hex_reg;
        has0       = 1'b0;
        ent        = '0;
        case (state_reg)
            ST_WORD: begin
                has0 = 1'b1;
                if (is_delim) begin
                    ent.r0.kind = K_SEND;
                    ent.two     = idle_has;
                    ent.r1      = idle_res;
                    state_next  = idle_state;
                end else begin
                    ent.r0.kind = K_TEXT;
                    ent.r0.ch   = in_byte;
                end
            end
            ST_STR: begin
                if (end_of_input) begin
                    has0        = 1'b1;
                    ent.r0.kind = K_ERR;
                    ent.r0.err  = E_UNTERM;
                    state_next  = ST_IDLE;
                end else if (in_byte == "\"") begin
                    has0        = 1'b1;
                    ent.r0.kind = K_SEND;
                    state_next  = ST_IDLE;
                end else if (in_byte == "\\") begin
                    state_next = ST_ESC;
                end else begin
                    has0        = 1'b1;
                    ent.r0.kind = K_TEXT;
                    ent.r0.ch   = in_byte;
                end
            end
            ST_ESC: begin
                if (end_of_input) begin
                    has0        = 1'b1;
                    ent.r0.kind = K_ERR;
                    ent.r0.err  = E_UNTERM;
                    state_next  = ST_IDLE;
                end else if (in_byte == "x" || in_byte == "X") begin
                    hex_next   = 4'd0;
                    state_next = ST_HEX1;
                end else begin
                    has0        = 1'b1;
                    ent.r0.kind = K_TEXT;
                    ent.r0.ch   = in_byte;
                    state_next  = ST_STR;
                end
            end
            ST_SLASH: begin
                if (!end_of_input && in_byte == "/") begin
                    state_next = ST_LINE;
                end else if (!end_of_input && in_byte == "*") begin
                    state_next = ST_BLOCK;
                end else begin
                    has0        = 1'b1;
                    ent.r0.kind = K_ERR;
                    ent.r0.err  = E_SLASH;
                    state_next  = ST_IDLE;
                end
            end
            ST_LINE: begin
                if (end_of_input) begin
                    has0        = 1'b1;
                    ent.r0.kind = K_END;
                    state_next  = ST_IDLE;
                end else if (in_byte == 8'h0a) begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLOCK: begin
                if (end_of_input) begin
                    has0        = 1'b1;
                    ent.r0.kind = K_ERR;
                    ent.r0.err  = E_COMMENT;
                    state_next  = ST_IDLE;
                end else if (in_byte == "*") begin
                    state_next = ST_STAR;
                end
            end
            ST_STAR: begin
                if (end_of_input) begin
                    has0        = 1'b1;
                    ent.r0.kind = K_ERR;
                    ent.r0.err  = E_COMMENT;
                    state_next  = ST_IDLE;
                end else if (in_byte == "/") begin
                    state_next = ST_IDLE;
                end else if (in_byte != "*") begin
                    state_next = ST_BLOCK;
                end
            end
            ST_HEX1: begin
                if (!hex_ok) begin
                    has0        = 1'b1;
                    ent.r0.kind = K_ERR;
                    ent.r0.err  = E_HEX;
                    state_next  = ST_IDLE;
                end else begin
                    hex_next   = hex_val;
                    state_next = ST_HEX2;
                end
            end
            ST_HEX2: begin
                has0 = 1'b1;
                if (!hex_ok) begin
                    ent.r0.kind = K_ERR;
                    ent.r0.err  = E_HEX;
                    state_next  = ST_IDLE;
                end else begin
                    ent.r0.kind = K_TEXT;
                    ent.r0.ch   = {hex_reg, hex_val};
                    state_next  = ST_STR;
                end
            end
            default: begin
                has0       = idle_has;
                ent.r0     = idle_res;
                state_next = idle_state;
            end
        endcase
    end

    assign push = accept && has0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hex_reg   <= 4'd0;
        end else if (accept) begin
            state_reg <= state_next;
            hex_reg   <= hex_next;
        end
    end

endmodule

// ===== sv/atl_queue.sv =====
// ----------------------------------------------------------------------------
// atl_queue: short result queue
// Holds entries between the lexer state machine and the output serializer.
// ----------------------------------------------------------------------------
module atl_queue import atl_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  qent_t wr_ent,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output qent_t rd_ent
);

    qent_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == QCNT_W'(QDEPTH));
    assign empty  = (count_reg == '0);
    assign rd_ent = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue read while empty");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a write");
`endif

endmodule

// ===== sv/atl_back.sv =====
// ----------------------------------------------------------------------------
// atl_back: output serializer
// Takes queue entries apart into single result beats and holds each one in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module atl_back import atl_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_empty,
    input  qent_t q_ent,
    output logic  q_pop,
    output logic  m_valid,
    output res_t  m_res,
    output logic  m_last,
    input  logic  m_ready
);

    logic m_valid_reg, m_valid_next;
    res_t m_res_reg, m_res_next;
    logic m_last_reg, m_last_next;
    logic sel_reg, sel_next;
    logic load, take;

    assign load = !m_valid_reg || m_ready;
    assign take = load && !q_empty;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_last_next  = m_last_reg;
        sel_next     = sel_reg;
        q_pop        = 1'b0;
        if (load) begin
            m_valid_next = !q_empty;
        end
        if (take) begin
            if (sel_reg) begin
                m_res_next  = q_ent.r1;
                m_last_next = 1'b1;
                sel_next    = 1'b0;
                q_pop       = 1'b1;
            end else if (q_ent.two) begin
                // First of two results: the entry stays at the head.
                m_res_next  = q_ent.r0;
                m_last_next = 1'b0;
                sel_next    = 1'b1;
            end else begin
                m_res_next  = q_ent.r0;
                m_last_next = 1'b1;
                q_pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sel_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            sel_reg     <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign m_last  = m_last_reg;

`ifndef SYNTH
    a_sel_head: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (!q_empty && q_ent.two)) else $error("second half without entry");
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("second result of a pair missing");
    a_pair_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_res.kind == K_SEND))
        else $error("first of two results is not a string end");
`endif

endmodule

// ===== sv/atv_token_lexer.sv =====
// ----------------------------------------------------------------------------
// atv_token_lexer: byte-serial tokenizer
// The input channel carries one character per beat in s_tdata, with s_tuser
// set to mark the end of input. Every input beat causes zero, one or two
// result beats on the output channel: kind, text character and error code
// in m_tdata, and m_tlast on the final result of that input beat.
// Throughput is one input beat per cycle while the queue is not full; an
// input beat with two results gives them on the output one after the
// other, one result per cycle being the output register's rate while the
// receiver is ready. The accepting edge writes a result into the queue,
// and the output register is loaded from the queue after that.
// A four-entry queue parts the lexer state machine from the serializer, so
// input keeps flowing while the receiver stalls until the queue fills; then
// s_tready drops. Reset returns the lexer to idle and empties the queue
// and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module atv_token_lexer import atl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] kind, [10:3] text_char, [12:11] error_code
    output logic        m_tlast
);

    logic  accept;
    logic  push, full, pop, empty;
    qent_t wr_ent, rd_ent;
    res_t  res;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    atl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_byte      (s_tdata),
        .end_of_input (s_tuser),
        .push         (push),
        .ent          (wr_ent)
    );

    atl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_ent  (wr_ent),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .rd_ent  (rd_ent)
    );

    atl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (empty),
        .q_ent   (rd_ent),
        .q_pop   (pop),
        .m_valid (m_tvalid),
        .m_res   (res),
        .m_last  (m_tlast),
        .m_ready (m_tready)
    );

    assign m_tdata = {3'b000, res};

endmodule
